// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/trme_pkg.sv -----
package trme_pkg;

    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;
    localparam int REG_AW     = $clog2(NUM_REGS);
    localparam int DATA_W     = 32;
    localparam int PC_W       = 16;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 56;

    typedef enum logic [2:0] {
        ACT_ADDI = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_PRT  = 3'd3,
        ACT_J    = 3'd4,
        ACT_SLT  = 3'd5,
        ACT_BEQZ = 3'd6
    } t_action;

    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        logic [PC_W-1:0]   next_pc;
        logic              done;
    } t_res;

    function automatic logic reg_in_range(logic [REG_IDX_W-1:0] idx);
        return int'(idx) < NUM_REGS;
    endfunction

    function automatic logic [REG_AW-1:0] reg_addr(logic [REG_IDX_W-1:0] idx);
        return REG_AW'(idx);
    endfunction

endpackage

// ----- sv/trme_ram.sv -----
module trme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- sv/trme_regfile.sv -----
module trme_regfile (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [trme_pkg::REG_AW-1:0]      i_rd_addr_a,
    input  logic [trme_pkg::REG_AW-1:0]      i_rd_addr_b,
    input  trme_pkg::t_wr                    i_wr,
    output logic [trme_pkg::DATA_W-1:0]      o_op_a,
    output logic [trme_pkg::DATA_W-1:0]      o_op_b
);
    import trme_pkg::*;

    logic [DATA_W-1:0]   w_dout_a;
    logic [DATA_W-1:0]   w_dout_b;
    logic [NUM_REGS-1:0] r_vld;
    logic [REG_AW-1:0]   r_addr_a;
    logic [REG_AW-1:0]   r_addr_b;
    t_wr                 r_byp;

    // two copies, written together, one read port each
    trme_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr_a),
        .o_rdata (w_dout_a)
    );

    trme_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_addr_b),
        .o_rdata (w_dout_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_byp.en <= 1'b0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
            r_byp            <= i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_addr_a <= i_rd_addr_a;
            r_addr_b <= i_rd_addr_b;
        end
    end

    // last write may have landed on the same edge as the read: take it from the bypass.
    // It always holds the newest contents of its entry, so a late match is harmless.
    always_comb begin
        if (r_byp.en && r_byp.addr == r_addr_a) begin
            o_op_a = r_byp.data;
        end else if (r_vld[r_addr_a]) begin
            o_op_a = w_dout_a;
        end else begin
            o_op_a = '0;
        end
    end

    always_comb begin
        if (r_byp.en && r_byp.addr == r_addr_b) begin
            o_op_b = r_byp.data;
        end else if (r_vld[r_addr_b]) begin
            o_op_b = w_dout_b;
        end else begin
            o_op_b = '0;
        end
    end

endmodule

// ----- sv/trme_exec.sv -----
module trme_exec (
    input  logic [2:0]                   i_act,
    input  logic [trme_pkg::REG_IDX_W-1:0] i_dst,
    input  logic                         i_ok_a,
    input  logic                         i_ok_b,
    input  logic [trme_pkg::DATA_W-1:0]  i_op_a,
    input  logic [trme_pkg::DATA_W-1:0]  i_op_b,
    input  logic [trme_pkg::DATA_W-1:0]  i_imm,
    input  logic [trme_pkg::PC_W-1:0]    i_pc,
    input  logic [trme_pkg::PC_W-1:0]    i_len,
    output trme_pkg::t_res               o_res,
    output trme_pkg::t_wr                o_wr
);
    import trme_pkg::*;

    logic [DATA_W-1:0] w_a;
    logic [DATA_W-1:0] w_b;
    logic [PC_W-1:0]   w_pc_inc;
    logic [PC_W-1:0]   w_pc_jmp;
    logic [PC_W-1:0]   w_pc;
    t_action           w_act;

    assign w_a      = i_ok_a ? i_op_a : '0;
    assign w_b      = i_ok_b ? i_op_b : '0;
    assign w_pc_inc = i_pc + PC_W'(1);
    assign w_pc_jmp = i_pc + i_imm[PC_W-1:0];
    assign w_act    = t_action'(i_act);

    always_comb begin
        o_wr.en   = 1'b0;
        o_wr.addr = reg_addr(i_dst);
        o_wr.data = '0;
        o_res.print_valid = 1'b0;
        o_res.print_value = '0;
        w_pc = w_pc_inc;
        unique case (w_act)
            ACT_ADDI: begin
                o_wr.en   = 1'b1;
                o_wr.data = w_a + i_imm;
            end
            ACT_ADD: begin
                o_wr.en   = 1'b1;
                o_wr.data = w_a + w_b;
            end
            ACT_SUB: begin
                o_wr.en   = 1'b1;
                o_wr.data = w_a - w_b;
            end
            ACT_PRT: begin
                o_res.print_valid = 1'b1;
                o_res.print_value = w_a;
            end
            ACT_J: begin
                w_pc = w_pc_jmp;
            end
            ACT_SLT: begin
                o_wr.en   = 1'b1;
                o_wr.data = DATA_W'($signed(w_a) < $signed(w_b));
            end
            ACT_BEQZ: begin
                w_pc = (w_a == '0) ? w_pc_jmp : w_pc_inc;
            end
            default: begin
                // unused code: counter holds, nothing written
                w_pc = i_pc;
            end
        endcase
        o_wr.en       = o_wr.en & reg_in_range(i_dst);
        o_res.next_pc = w_pc;
        o_res.done    = w_pc >= i_len;
    end

endmodule

// ----- sv/tiny_register_machine_execute.sv -----
// Channel   Direction  Beat when               Contents
// s_*       in         s_tvalid & s_tready     one decoded instruction
// m_*       out        m_tvalid & m_tready     one result per instruction
// i_cfg_*   in         i_cfg_valid & o_cfg_ready  program length
//
// One instruction per cycle sustained while the output is not stalled; from input beat to output beat:
// register file read (synchronous RAM) on the input beat, execute and write back,
// output register.
// Back-to-back dependent instructions are served by a one-entry write bypass.
// Synchronous active-low reset; register file reads as zero until written, no clearing pass.
// A stalled output stalls the execute stage only when it is occupied; o_cfg_ready is always high.
module tiny_register_machine_execute (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // dst_reg[2:0], src1_reg[5:3], src2_reg[8:6], imm[40:9], zero pad
    input  logic [trme_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[2:0]
    input  logic [2:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // print_value[31:0], next_pc[47:32], done_res[48], zero pad
    output logic [trme_pkg::M_TDATA_W-1:0]   m_tdata,
    // print_valid[0]
    output logic                             m_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [trme_pkg::PC_W-1:0]        i_cfg_data
);
    import trme_pkg::*;

    logic [REG_IDX_W-1:0] w_dst;
    logic [REG_IDX_W-1:0] w_src1;
    logic [REG_IDX_W-1:0] w_src2;
    logic [REG_IDX_W-1:0] w_sel_a;
    logic                 w_accept;
    logic                 w_adv;
    t_action              w_act;
    t_res                 w_res;
    t_wr                  w_exec_wr;
    t_wr                  w_wr;
    logic [DATA_W-1:0]    w_op_a;
    logic [DATA_W-1:0]    w_op_b;

    logic                 r_s1_vld;
    logic [2:0]           r_s1_act;
    logic [REG_IDX_W-1:0] r_s1_dst;
    logic                 r_s1_ok_a;
    logic                 r_s1_ok_b;
    logic [DATA_W-1:0]    r_s1_imm;
    logic [PC_W-1:0]      r_pc;
    logic [PC_W-1:0]      r_len;
    logic                 r_out_vld;
    t_res                 r_res;
    logic [PC_W-1:0]      n_pc;

    assign w_dst  = s_tdata[2:0];
    assign w_src1 = s_tdata[5:3];
    assign w_src2 = s_tdata[8:6];
    assign w_act  = t_action'(s_tuser);

    // PRT and BEQZ look at dst, everything else at src1
    assign w_sel_a = (w_act == ACT_PRT || w_act == ACT_BEQZ) ? w_dst : w_src1;

    assign w_adv    = r_s1_vld && (!r_out_vld || m_tready);
    assign s_tready = !r_s1_vld || w_adv;
    assign w_accept = s_tvalid && s_tready;

    trme_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (reg_addr(w_sel_a)),
        .i_rd_addr_b (reg_addr(w_src2)),
        .i_wr        (w_wr),
        .o_op_a      (w_op_a),
        .o_op_b      (w_op_b)
    );

    trme_exec u_exec (
        .i_act  (r_s1_act),
        .i_dst  (r_s1_dst),
        .i_ok_a (r_s1_ok_a),
        .i_ok_b (r_s1_ok_b),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .i_imm  (r_s1_imm),
        .i_pc   (r_pc),
        .i_len  (r_len),
        .o_res  (w_res),
        .o_wr   (w_exec_wr)
    );

    always_comb begin
        w_wr    = w_exec_wr;
        w_wr.en = w_exec_wr.en && w_adv;
        n_pc    = w_adv ? w_res.next_pc : r_pc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pc      <= '0;
            r_len     <= '0;
        end else begin
            r_pc <= n_pc;
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_act  <= s_tuser;
            r_s1_dst  <= w_dst;
            r_s1_ok_a <= reg_in_range(w_sel_a);
            r_s1_ok_b <= reg_in_range(w_src2);
            r_s1_imm  <= s_tdata[40:9];
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_out_vld;
    assign m_tuser     = r_res.print_valid;
    assign m_tdata     = {(M_TDATA_W - DATA_W - PC_W - 1)'(0), r_res.done,
                          r_res.next_pc, r_res.print_value};

endmodule

// ----- sv/trme_checker.sv -----
`include "assert_macros.svh"

module trme_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [trme_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [trme_pkg::PC_W-1:0]       i_cfg_data
);
    import trme_pkg::*;

    logic [PC_W-1:0]      r_len;
    logic                 w_quiet;
    logic                 w_zero_len;
    logic                 w_held;
    logic [M_TDATA_W+1:0] w_out;

    // shadow of the program length as seen on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_len <= i_cfg_data;
        end
    end

    assign w_quiet    = m_tvalid && !m_tuser;
    assign w_zero_len = m_tvalid && (r_len == '0);
    assign w_held     = m_tvalid && !m_tready;
    assign w_out      = {m_tvalid, m_tuser, m_tdata};

    `CHK_IMPLY(a_prt_value, i_clk, i_rst_n, w_quiet, m_tdata[31:0] == '0, "value on non-print")
    `CHK_IMPLY(a_done_len0, i_clk, i_rst_n, w_zero_len, m_tdata[48], "done clear, length zero")
    `CHK_IMPLY(a_rdy_empty, i_clk, i_rst_n, !m_tvalid, s_tready, "input stalled, output empty")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, w_held, m_tvalid && $stable(w_out), "held beat changed")

endmodule

bind tiny_register_machine_execute trme_checker u_trme_checker (.*);
